[design/free_block_table_coalescing_unit_assert.svh]
// Assertion macros shared by the free block table coalescing unit.
`ifndef FREE_BLOCK_TABLE_COALESCING_UNIT_ASSERT_SVH
`define FREE_BLOCK_TABLE_COALESCING_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition that must hold in the same cycle as the trigger.
`define FBTCU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("free block table: same-cycle check failed");
// Condition that must hold in the cycle after the trigger.
`define FBTCU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("free block table: next-cycle check failed");
`else
`define FBTCU_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define FBTCU_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[design/fbtcu_pkg.sv]
// Shared types, field widths and codes of the free block table coalescing unit.
`timescale 1ns / 1ps
`default_nettype none

package fbtcu_pkg;

  localparam int CMD_W      = 2;
  localparam int START_W    = 16;
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam int OUT_COUNT_LSB  = START_W + SIZE_W;
  localparam int OUT_STATUS_BIT = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_PAD        = OUT_DATA_W - (OUT_STATUS_BIT + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READOUT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_SRCH,
    OP_DECIDE,
    OP_SHUP,
    OP_SHDN,
    OP_REPLY,
    OP_RO
  } dp_op_t;

  typedef enum logic [2:0] {
    ACT_INSERT,
    ACT_FULL,
    ACT_PRED,
    ACT_SUCC,
    ACT_BOTH
  } act_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic srch_done;
    act_t act;
    logic up_done;
    logic down_done;
    logic out_free;
    logic ro_last;
  } dp_sts_t;

  function automatic logic [OUT_DATA_W-1:0] pack_result(
    input logic [START_W-1:0] start,
    input logic [SIZE_W-1:0]  size,
    input logic [COUNT_W-1:0] count,
    input logic               status
  );
    return {{OUT_PAD{1'b0}}, status, count, size, start};
  endfunction

endpackage

`default_nettype wire

[design/fbtcu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fbtcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/fbtcu_ctrl.sv]
// Sequencing state machine of the free block table coalescing unit.
`timescale 1ns / 1ps
`default_nettype none

module fbtcu_ctrl import fbtcu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire cmd_t    in_cmd,
  output dp_ctl_t      ctl,
  input  wire dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_DECIDE,
    ST_SHUP,
    ST_SHDN,
    ST_REPLY,
    ST_RO
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_IDLE;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.op = OP_ACCEPT;
          case (in_cmd)
            CMD_LOAD, CMD_RELEASE: state_nxt = ST_SRCH;
            CMD_READOUT:           state_nxt = ST_RO;
            default:               state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_SRCH: begin
        ctl.op = OP_SRCH;
        if (sts.srch_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctl.op = OP_DECIDE;
        case (sts.act)
          ACT_BOTH:   state_nxt = ST_SHDN;
          ACT_INSERT: state_nxt = ST_SHUP;
          default:    state_nxt = ST_REPLY;
        endcase
      end
      ST_SHUP: begin
        ctl.op = OP_SHUP;
        if (sts.up_done) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_SHDN: begin
        ctl.op = OP_SHDN;
        if (sts.down_done) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: begin
        ctl.op = OP_REPLY;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RO: begin
        ctl.op = OP_RO;
        if (sts.out_free && sts.ro_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/fbtcu_dpath.sv]
// Table storage, search, shift and result register of the free block table unit.
`timescale 1ns / 1ps
`default_nettype none

module fbtcu_dpath import fbtcu_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_ctl_t            ctl,
  output dp_sts_t                 sts,
  input  wire cmd_t               in_cmd,
  input  wire logic [START_W-1:0] in_start,
  input  wire logic [SIZE_W-1:0]  in_size,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = ADDR_BITS + 1;
  localparam int EW = ADDR_BITS + SW;
  localparam int XW = ADDR_BITS + 2;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
  localparam logic [SW-1:0] SIZE_LIM = {1'b1, {ADDR_BITS{1'b0}}};

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SIZE_LIM}) ? SIZE_LIM : s[SW-1:0];
  endfunction

  // Table RAM, one word per entry: size above start.
  logic [EW-1:0] rd_word, wr_word;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  fbtcu_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  cmd_t                  cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0]  st_r, st_nxt;
  logic [SW-1:0]         sz_r, sz_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         slot_r, slot_nxt;
  logic [ADDR_BITS-1:0]  pred_start_r, pred_start_nxt;
  logic [SW-1:0]         pred_sum_r, pred_sum_nxt;
  logic                  pred_adj_r, pred_adj_nxt;
  logic [SW-1:0]         succ_size_r, succ_size_nxt;
  logic [SW-1:0]         succ_sum_r, succ_sum_nxt;
  logic                  succ_adj_r, succ_adj_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  // Input conversion: start wraps to the address space, size saturates to it.
  logic [ADDR_BITS+START_W-1:0] in_start_x;
  logic [SW+SIZE_W-1:0]         in_size_x;
  logic [ADDR_BITS-1:0]         in_st;
  logic [SW-1:0]                in_sz;

  assign in_start_x = {{ADDR_BITS{1'b0}}, in_start};
  assign in_st      = in_start_x[ADDR_BITS-1:0];
  assign in_size_x  = {{SW{1'b0}}, in_size};
  assign in_sz      = (in_size_x > {{SIZE_W{1'b0}}, SIZE_LIM}) ? SIZE_LIM : in_size_x[SW-1:0];

  logic [ADDR_BITS-1:0] rd_start;
  logic [SW-1:0]        rd_size;
  assign rd_start = rd_word[ADDR_BITS-1:0];
  assign rd_size  = rd_word[EW-1:ADDR_BITS];

  logic [CW:0] idx_x, idx_p1, idx_p2, idx_m2, slot_p1, slot_m1, cnt_x, cnt_m1;
  assign idx_x   = {1'b0, idx_r};
  assign idx_p1  = idx_x + (CW+1)'(1);
  assign idx_p2  = idx_x + (CW+1)'(2);
  assign idx_m2  = idx_x - (CW+1)'(2);
  assign slot_p1 = {1'b0, slot_r} + (CW+1)'(1);
  assign slot_m1 = {1'b0, slot_r} - (CW+1)'(1);
  assign cnt_x   = {1'b0, count_r};
  assign cnt_m1  = cnt_x - (CW+1)'(1);

  logic          at_end, below, pred_adj_w, succ_adj_w, ro_last, out_free;
  logic [XW-1:0] pred_end, blk_end;
  act_t          act;

  assign at_end     = (idx_r == count_r);
  assign below      = (rd_start < st_r);
  assign pred_end   = XW'(rd_start) + XW'(rd_size);
  assign blk_end    = XW'(st_r) + XW'(sz_r);
  assign pred_adj_w = (pred_end == XW'(st_r));
  assign succ_adj_w = (blk_end == XW'(rd_start));
  assign ro_last    = (count_r == '0) || (idx_p1 == cnt_x);
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    if (cmd_r == CMD_RELEASE && pred_adj_r && succ_adj_r) begin
      act = ACT_BOTH;
    end else if (cmd_r == CMD_RELEASE && pred_adj_r) begin
      act = ACT_PRED;
    end else if (cmd_r == CMD_RELEASE && succ_adj_r) begin
      act = ACT_SUCC;
    end else if (count_r == FULL_CNT) begin
      act = ACT_FULL;
    end else begin
      act = ACT_INSERT;
    end
  end

  // Result fields in the output widths.
  logic [START_W+ADDR_BITS-1:0] ent_start_x;
  logic [SIZE_W+SW-1:0]         ent_size_x;
  logic [COUNT_W+CW-1:0]        cnt_out_x;
  assign ent_start_x = {{START_W{1'b0}}, rd_start};
  assign ent_size_x  = {{SIZE_W{1'b0}}, rd_size};
  assign cnt_out_x   = {{COUNT_W{1'b0}}, count_r};

  always_comb begin
    cmd_nxt        = cmd_r;
    st_nxt         = st_r;
    sz_nxt         = sz_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    pred_start_nxt = pred_start_r;
    pred_sum_nxt   = pred_sum_r;
    pred_adj_nxt   = pred_adj_r;
    succ_size_nxt  = succ_size_r;
    succ_sum_nxt   = succ_sum_r;
    succ_adj_nxt   = succ_adj_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = slot_r[AW-1:0];
    wr_word        = rd_word;
    case (ctl.op)
      OP_ACCEPT: begin
        cmd_nxt      = in_cmd;
        st_nxt       = in_st;
        sz_nxt       = in_sz;
        idx_nxt      = '0;
        pred_adj_nxt = 1'b0;
        succ_adj_nxt = 1'b0;
        status_nxt   = 1'b0;
      end
      OP_SRCH: begin
        // The RAM output holds entry idx_r; fetch the following one.
        rd_addr = idx_p1[AW-1:0];
        if (at_end) begin
          slot_nxt = idx_r;
        end else if (below) begin
          pred_start_nxt = rd_start;
          pred_sum_nxt   = sat_add(rd_size, sz_r);
          pred_adj_nxt   = pred_adj_w;
          idx_nxt        = idx_p1[CW-1:0];
        end else begin
          slot_nxt      = idx_r;
          succ_size_nxt = rd_size;
          succ_sum_nxt  = sat_add(rd_size, sz_r);
          succ_adj_nxt  = succ_adj_w;
        end
      end
      OP_DECIDE: begin
        case (act)
          ACT_BOTH: begin
            wr_en   = 1'b1;
            wr_addr = slot_m1[AW-1:0];
            wr_word = {sat_add(pred_sum_r, succ_size_r), pred_start_r};
            rd_addr = slot_p1[AW-1:0];
            idx_nxt = slot_r;
          end
          ACT_PRED: begin
            wr_en   = 1'b1;
            wr_addr = slot_m1[AW-1:0];
            wr_word = {pred_sum_r, pred_start_r};
          end
          ACT_SUCC: begin
            wr_en   = 1'b1;
            wr_addr = slot_r[AW-1:0];
            wr_word = {succ_sum_r, st_r};
          end
          ACT_FULL: begin
            status_nxt = 1'b1;
          end
          default: begin
            rd_addr = cnt_m1[AW-1:0];
            idx_nxt = count_r;
          end
        endcase
      end
      OP_SHUP: begin
        wr_en = 1'b1;
        if (idx_r == slot_r) begin
          wr_addr   = slot_r[AW-1:0];
          wr_word   = {sz_r, st_r};
          count_nxt = count_r + CW'(1);
        end else begin
          wr_addr = idx_r[AW-1:0];
          wr_word = rd_word;
          rd_addr = idx_m2[AW-1:0];
          idx_nxt = idx_r - CW'(1);
        end
      end
      OP_SHDN: begin
        if (idx_p1 == cnt_x) begin
          count_nxt = count_r - CW'(1);
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_word = rd_word;
          rd_addr = idx_p2[AW-1:0];
          idx_nxt = idx_p1[CW-1:0];
        end
      end
      OP_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pack_result('0, '0, cnt_out_x[COUNT_W-1:0], status_r);
          out_user_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
        end
      end
      OP_RO: begin
        rd_addr = out_free ? idx_p1[AW-1:0] : idx_r[AW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = ro_last;
          idx_nxt       = idx_p1[CW-1:0];
          if (count_r == '0) begin
            out_data_nxt = pack_result('0, '0, cnt_out_x[COUNT_W-1:0], 1'b0);
            out_user_nxt = 1'b0;
          end else begin
            out_data_nxt = pack_result(ent_start_x[START_W-1:0], ent_size_x[SIZE_W-1:0],
                                       cnt_out_x[COUNT_W-1:0], 1'b0);
            out_user_nxt = 1'b1;
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    st_r         <= st_nxt;
    sz_r         <= sz_nxt;
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    pred_start_r <= pred_start_nxt;
    pred_sum_r   <= pred_sum_nxt;
    pred_adj_r   <= pred_adj_nxt;
    succ_size_r  <= succ_size_nxt;
    succ_sum_r   <= succ_sum_nxt;
    succ_adj_r   <= succ_adj_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign sts.srch_done = at_end || !below;
  assign sts.act       = act;
  assign sts.up_done   = (idx_r == slot_r);
  assign sts.down_done = (idx_p1 == cnt_x);
  assign sts.out_free  = out_free;
  assign sts.ro_last   = ro_last;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[design/free_block_table_coalescing_unit.sv]
// Top level of the address-ordered free block table with release coalescing.
//
// The block keeps up to TABLE_ENTRIES free blocks (start, size) sorted by start.
// Each item on the in_ channel carries a command in in_tuser: load inserts a
// block at its sorted place, release inserts it and merges it with adjacent
// neighbors, and readout streams every entry in address order.
// Load, release and the unused command give one result item with tlast set;
// status is 1 when an insert hit a full table and was dropped.
// Readout gives one item per entry (tuser set) with tlast on the final one,
// or a single empty item with tlast when the table holds nothing.
// A load or release walks the table RAM one entry per cycle, first up to the
// sorted slot and then over the entries it shifts, and a readout walks the
// entries in address order. The table RAM gives one read per cycle.
// One item is worked on at a time; in_tready is high only while idle.
// Results leave through an output register, so a stalled receiver holds the
// current item and freezes the walk of a readout until it is taken.
// Reset clears the entry count and the output valid flag; the table RAM itself
// is not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "free_block_table_coalescing_unit_assert.svh"

module free_block_table_coalescing_unit import fbtcu_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // block_start[15:0], block_size[32:16]
  input  wire logic [CMD_W-1:0]      in_tuser,   // command[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // entry_start[15:0], entry_size[32:16],
                                                 // free_count[37:33], status[38]
  output logic                       out_tuser,  // entry_valid[0]
  output logic                       out_tlast
);

  dp_ctl_t ctl;
  dp_sts_t sts;
  cmd_t    in_cmd;

  assign in_cmd = cmd_t'(in_tuser);

  // The controller sequences search, merge decision, shifting and replies.
  fbtcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_cmd),
    .ctl       (ctl),
    .sts       (sts)
  );

  // The datapath owns the table RAM, the entry count and the output register.
  fbtcu_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (in_cmd),
    .in_start   (in_tdata[START_W-1:0]),
    .in_size    (in_tdata[START_W +: SIZE_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Only one item is in work at a time.
  `FBTCU_ASSERT_NXT(a_single_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A table entry read out never reports a dropped insert.
  `FBTCU_ASSERT_IMP(a_entry_status_ok, clk, rst_n, out_tvalid && out_tuser, !out_tdata[OUT_STATUS_BIT])
  // The reported count never exceeds the table depth.
  `FBTCU_ASSERT_IMP(a_count_bound, clk, rst_n, out_tvalid, out_tdata[OUT_COUNT_LSB +: COUNT_W] <= TABLE_ENTRIES)
  // A reply that finds the output free shows up as a final item next cycle.
  `FBTCU_ASSERT_NXT(a_reply_lands, clk, rst_n, ctl.op == OP_REPLY && sts.out_free, out_tvalid && out_tlast)

endmodule

`default_nettype wire

[sim/fbtcu_table_checker.sv]
// Free block table checker: mirrors the table, predicts result items and compares them.
`timescale 1ns / 1ps

module fbtcu_table_checker import fbtcu_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending_replies
);

  // Sizes are capped at the size of the whole address space.
  localparam int SPACE_WORDS = 1 << START_W;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic               status;
    logic               last;
  } reply_t;

  logic [START_W-1:0] free_start [TABLE_ENTRIES];
  logic [SIZE_W-1:0]  free_size  [TABLE_ENTRIES];
  int                 free_blocks = 0;
  reply_t             expected_replies [$];
  int                 errors = 0;

  function automatic logic [SIZE_W-1:0] sat_sum(input int a, input int b);
    logic [SIZE_W-1:0] s;
    if (a + b > SPACE_WORDS) s = SIZE_W'(SPACE_WORDS);
    else s = SIZE_W'(a + b);
    return s;
  endfunction

  function automatic int first_at_or_above(input int addr);
    int p;
    p = 0;
    while (p < free_blocks && int'(free_start[p]) < addr) p++;
    return p;
  endfunction

  function automatic bit insert_block(input int p, input logic [START_W-1:0] st,
                                      input logic [SIZE_W-1:0] sz);
    int i;
    if (free_blocks >= TABLE_ENTRIES) return 1'b0;
    for (i = free_blocks; i > p; i--) begin
      free_start[i] = free_start[i-1];
      free_size[i]  = free_size[i-1];
    end
    free_start[p] = st;
    free_size[p]  = sz;
    free_blocks++;
    return 1'b1;
  endfunction

  // Returns the status bit: 1 when the block needed a new slot and none was left.
  function automatic logic release_block(input logic [START_W-1:0] st,
                                         input logic [SIZE_W-1:0] sz);
    int  s;
    int  i;
    bit  pred;
    bit  succ;
    s    = first_at_or_above(st);
    pred = s > 0 && int'(free_start[s-1]) + int'(free_size[s-1]) == int'(st);
    succ = s < free_blocks && int'(st) + int'(sz) == int'(free_start[s]);
    if (pred && succ) begin
      free_size[s-1] = sat_sum(sat_sum(free_size[s-1], sz), free_size[s]);
      for (i = s; i + 1 < free_blocks; i++) begin
        free_start[i] = free_start[i+1];
        free_size[i]  = free_size[i+1];
      end
      free_blocks--;
      return 1'b0;
    end
    if (pred) begin
      free_size[s-1] = sat_sum(free_size[s-1], sz);
      return 1'b0;
    end
    if (succ) begin
      free_start[s] = st;
      free_size[s]  = sat_sum(free_size[s], sz);
      return 1'b0;
    end
    return !insert_block(s, st, sz);
  endfunction

  function automatic reply_t make_reply(input logic [START_W-1:0] st,
                                        input logic [SIZE_W-1:0] sz, input logic valid,
                                        input logic status, input logic last);
    reply_t r;
    r.start  = st;
    r.size   = sz;
    r.valid  = valid;
    r.count  = free_blocks[COUNT_W-1:0];
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  task automatic predict_item(input cmd_t cmd, input logic [START_W-1:0] st,
                              input logic [SIZE_W-1:0] raw_sz);
    logic [SIZE_W-1:0] sz;
    logic              status;
    int                i;
    if (int'(raw_sz) > SPACE_WORDS) sz = SIZE_W'(SPACE_WORDS);
    else sz = raw_sz;
    status = 1'b0;
    case (cmd)
      CMD_READOUT: begin
        if (free_blocks == 0) begin
          expected_replies.push_back(make_reply('0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i < free_blocks; i++)
            expected_replies.push_back(make_reply(free_start[i], free_size[i], 1'b1, 1'b0,
                                                  i == free_blocks - 1));
        end
        return;
      end
      CMD_LOAD:    status = !insert_block(first_at_or_above(st), st, sz);
      CMD_RELEASE: status = release_block(st, sz);
      default: ;
    endcase
    expected_replies.push_back(make_reply('0, '0, 1'b0, status, 1'b1));
  endtask

  always @(posedge clk) begin : watch_channels
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      free_blocks = 0;
    end else begin
      // Results first: an item accepted at this edge cannot have produced one yet.
      if (out_tvalid && out_tready) begin
        got.start  = out_tdata[START_W-1:0];
        got.size   = out_tdata[START_W +: SIZE_W];
        got.count  = out_tdata[OUT_COUNT_LSB +: COUNT_W];
        got.status = out_tdata[OUT_STATUS_BIT];
        got.valid  = out_tuser;
        got.last   = out_tlast;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result item with nothing expected: start %h size %h valid %b",
                     $time, got.start, got.size, got.valid);
        end else begin
          want = expected_replies.pop_front();
          if (got.start !== want.start || got.size !== want.size ||
              got.valid !== want.valid || got.count !== want.count ||
              got.status !== want.status || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch: expected start %h size %h valid %b count %0d",
                       $time, want.start, want.size, want.valid, want.count);
              $display("  expected status %b last %b, got start %h size %h valid %b",
                       want.status, want.last, got.start, got.size, got.valid);
              $display("  got count %0d status %b last %b",
                       got.count, got.status, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_item(cmd_t'(in_tuser), in_tdata[START_W-1:0], in_tdata[START_W +: SIZE_W]);
    end
    fail_count      <= errors;
    pending_replies <= expected_replies.size();
  end

endmodule

[sim/free_block_table_coalescing_unit_tb.sv]
// Testbench top for the free block table coalescing unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module free_block_table_coalescing_unit_tb;
  import fbtcu_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  // Longest plausible quiet stretch is a sender gap, a full walk of the table
  // and a receiver stall; this is many times that.
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 175;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int DRAIN_CYCLES  = 40;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = CMD_NOP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  int fail_count;
  int pending_replies;
  int idle_cycles = 0;
  int items_sent  = 0;

  // When set, neither the sender nor the receiver inserts idle cycles.
  bit quiet = 1'b0;

  // Address where the next well-formed region starts so that it joins the
  // previous one, and how many more stray entries the random part may leave.
  int chain_end;
  int spare_budget;

  free_block_table_coalescing_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ADDR_BITS    (START_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  fbtcu_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_replies(pending_replies)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sends one item: waits a random gap, presents the item and holds it until
  // the block takes it. tvalid stays high across back-to-back items.
  task automatic push_block(input cmd_t cmd, input logic [START_W-1:0] st,
                            input logic [SIZE_W-1:0] sz);
    int gap;
    gap = quiet ? 0 : $urandom_range(8, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W - START_W - SIZE_W){1'b0}}, sz, st};
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  // Holds the sender off until every predicted result item has been taken.
  // The checker's count is registered, so the task waits for a clock edge before its first look.
  task automatic wait_for_replies;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies != 0);
  endtask

  // Splits [base, end) into a few adjacent pieces and releases them in a
  // shuffled order, so all kinds of merge can show up and the region ends up as
  // one entry. A broken region leaves out one piece and may load some pieces
  // instead, which leaves extra entries behind.
  task automatic release_region(input int base, input bit broken);
    int n;
    int i;
    int j;
    int tmp;
    int hole;
    int piece_start [6];
    int piece_size  [6];
    int order       [6];
    cmd_t cmd;
    n = $urandom_range(6, 2);
    for (i = 0; i < n; i++) begin
      piece_size[i]  = $urandom_range(64, 1);
      piece_start[i] = (i == 0) ? base : piece_start[i-1] + piece_size[i-1];
      order[i]       = i;
    end
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i, 0);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    hole = broken ? $urandom_range(n - 1, 0) : -1;
    for (i = 0; i < n; i++) begin
      if (order[i] != hole) begin
        cmd = (broken && $urandom_range(5, 0) == 0) ? CMD_LOAD : CMD_RELEASE;
        push_block(cmd, piece_start[order[i]], piece_size[order[i]]);
      end
    end
    chain_end = piece_start[n-1] + piece_size[n-1];
  endtask

  initial begin : stimulus
    int   i;
    int   pick;
    int   base;
    bit   broken;
    bit   paused;
    cmd_t cmd;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table readout and the unused command.
    push_block(CMD_READOUT, '0, '0);
    push_block(CMD_NOP, 16'hA5C3, 17'h15A5A);

    // Coalescing: plain insert into an empty table, a second block with a gap,
    // a block that joins both neighbors, then successor-only and
    // predecessor-only merges. The table ends up as one entry 900/360.
    push_block(CMD_RELEASE, 1000, 100);
    push_block(CMD_RELEASE, 1200, 50);
    push_block(CMD_RELEASE, 1100, 100);
    push_block(CMD_RELEASE, 900, 100);
    push_block(CMD_RELEASE, 1250, 10);

    // Loads never merge, even when adjacent; an equal start goes first.
    push_block(CMD_LOAD, 1260, 5);
    push_block(CMD_LOAD, 1260, 7);

    // Field extremes: zero start and size, all-ones start and an oversized
    // block that is capped, then a successor merge that hits the size cap.
    push_block(CMD_LOAD, 16'h0000, 17'h00000);
    push_block(CMD_LOAD, 16'hFFFF, 17'h1FFFF);
    push_block(CMD_RELEASE, 16'hFFF0, 15);

    // Fill the table. A load and an unmerged release into the full table are
    // dropped; a readout shows all entries; a merge still succeeds when full.
    for (i = 0; i < 11; i++) push_block(CMD_LOAD, 2000 + 100 * i, 50);
    push_block(CMD_LOAD, 5000, 1);
    push_block(CMD_RELEASE, 6000, 1);
    push_block(CMD_READOUT, '0, '0);
    push_block(CMD_RELEASE, 2050, 50);

    wait_for_replies();

    // Close the remaining holes of the filled area, one entry fewer each time,
    // which leaves a single entry ending at 3050.
    items_sent = 0;
    for (i = 0; i < 9; i++) push_block(CMD_RELEASE, 2150 + 100 * i, 50);
    chain_end    = 3050;
    spare_budget = 6;
    paused       = 1'b0;

    // Mostly well-formed regions that keep joining the growing chain, with
    // readouts in between and some stray items of any kind.
    while (items_sent < RANDOM_ITEMS) begin
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        wait_for_replies();
        paused = 1'b1;
      end
      quiet <= ($urandom_range(4, 0) == 0);
      pick = $urandom_range(9, 0);
      if (pick < 7) begin
        base   = chain_end;
        broken = 1'b0;
        if (spare_budget > 0 && $urandom_range(7, 0) == 0) begin
          base = chain_end + $urandom_range(200, 1);
          spare_budget--;
        end
        if (spare_budget >= 2 && $urandom_range(5, 0) == 0) begin
          broken = 1'b1;
          spare_budget -= 2;
        end
        release_region(base, broken);
      end else if (pick < 9) begin
        push_block(CMD_READOUT, $urandom_range(16'hFFFF, 0), $urandom_range(17'h1FFFF, 0));
      end else begin
        cmd = cmd_t'($urandom_range(3, 0));
        if (cmd == CMD_LOAD || cmd == CMD_RELEASE) begin
          if (spare_budget > 0) spare_budget--;
          else cmd = CMD_READOUT;
        end
        push_block(cmd, $urandom_range(16'hFFFF, 0), $urandom_range(17'h1FFFF, 0));
      end
    end

    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_replies == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver: before each result item it stalls for a random number of cycles,
  // then keeps tready high until an item is taken.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(8, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
